// ===== src/printf_conversion_spec_parser_assert.svh =====
// Assertion macros used by the checker of the conversion specification parser.
`ifndef PRINTF_CONVERSION_SPEC_PARSER_ASSERT_SVH
`define PRINTF_CONVERSION_SPEC_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define PCSP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define PCSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pcsp_pkg.sv =====
`timescale 1ns / 1ps
package pcsp_pkg;

  localparam int unsigned CharBits   = 8;
  localparam int unsigned ArgBits    = 32;
  localparam int unsigned WidthBits  = 31;
  localparam int unsigned PrecBits   = 32;
  localparam int unsigned LenBits    = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrBits    = $clog2(QueueDepth);

  localparam logic [LenBits-1:0] LenNone = 3'd0;
  localparam logic [LenBits-1:0] LenHh   = 3'd1;
  localparam logic [LenBits-1:0] LenH    = 3'd2;
  localparam logic [LenBits-1:0] LenLl   = 3'd3;
  localparam logic [LenBits-1:0] LenL    = 3'd4;

  localparam logic [CharBits-1:0] ChMinus = 8'h2D;
  localparam logic [CharBits-1:0] ChPlus  = 8'h2B;
  localparam logic [CharBits-1:0] ChSpace = 8'h20;
  localparam logic [CharBits-1:0] ChHash  = 8'h23;
  localparam logic [CharBits-1:0] ChZero  = 8'h30;
  localparam logic [CharBits-1:0] ChOne   = 8'h31;
  localparam logic [CharBits-1:0] ChNine  = 8'h39;
  localparam logic [CharBits-1:0] ChStar  = 8'h2A;
  localparam logic [CharBits-1:0] ChDot   = 8'h2E;
  localparam logic [CharBits-1:0] ChLowH  = 8'h68;
  localparam logic [CharBits-1:0] ChLowL  = 8'h6C;

  typedef enum logic [3:0] {
    ClsMinus,
    ClsPlus,
    ClsSpace,
    ClsHash,
    ClsZero,
    ClsStar,
    ClsDigit,
    ClsDot,
    ClsH,
    ClsL,
    ClsOther
  } char_class_e;

  typedef struct packed {
    logic [CharBits-1:0]       character;
    logic signed [ArgBits-1:0] star_argument;
  } in_word_t;

  typedef struct packed {
    logic                       left_justify;
    logic                       force_sign;
    logic                       space_sign;
    logic                       alternate_form;
    logic                       zero_pad;
    logic [WidthBits-1:0]       field_width;
    logic signed [PrecBits-1:0] precision_value;
    logic [LenBits-1:0]         length_code;
    logic [CharBits-1:0]        specifier;
  } out_word_t;

  typedef struct packed {
    char_class_e          cls;
    logic [CharBits-1:0]  character;
    logic                 star_neg;
    logic [WidthBits-1:0] star_mag;
  } item_t;

endpackage

// ===== src/pcsp_front.sv =====
`timescale 1ns / 1ps
module pcsp_front #(
  parameter int unsigned NUMBER_BITS = 31
) (
  input  pcsp_pkg::in_word_t word_i,
  output pcsp_pkg::item_t    item_o
);

  localparam int unsigned MagBits = pcsp_pkg::ArgBits + 1;

  pcsp_pkg::char_class_e    cls;
  logic [MagBits-1:0]       mag;
  logic [NUMBER_BITS-1:0]   mag_sat;

  always_comb begin
    case (word_i.character)
      pcsp_pkg::ChMinus: cls = pcsp_pkg::ClsMinus;
      pcsp_pkg::ChPlus:  cls = pcsp_pkg::ClsPlus;
      pcsp_pkg::ChSpace: cls = pcsp_pkg::ClsSpace;
      pcsp_pkg::ChHash:  cls = pcsp_pkg::ClsHash;
      pcsp_pkg::ChZero:  cls = pcsp_pkg::ClsZero;
      pcsp_pkg::ChStar:  cls = pcsp_pkg::ClsStar;
      pcsp_pkg::ChDot:   cls = pcsp_pkg::ClsDot;
      pcsp_pkg::ChLowH:  cls = pcsp_pkg::ClsH;
      pcsp_pkg::ChLowL:  cls = pcsp_pkg::ClsL;
      default: begin
        if (word_i.character >= pcsp_pkg::ChOne && word_i.character <= pcsp_pkg::ChNine) begin
          cls = pcsp_pkg::ClsDigit;
        end else begin
          cls = pcsp_pkg::ClsOther;
        end
      end
    endcase
  end

  always_comb begin
    if (word_i.star_argument[pcsp_pkg::ArgBits-1]) begin
      mag = {1'b0, ~word_i.star_argument} + MagBits'(1);
    end else begin
      mag = {1'b0, word_i.star_argument};
    end
    if (|mag[MagBits-1:NUMBER_BITS]) begin
      mag_sat = {NUMBER_BITS{1'b1}};
    end else begin
      mag_sat = mag[NUMBER_BITS-1:0];
    end
  end

  assign item_o.cls       = cls;
  assign item_o.character = word_i.character;
  assign item_o.star_neg  = word_i.star_argument[pcsp_pkg::ArgBits-1];
  assign item_o.star_mag  = pcsp_pkg::WidthBits'(mag_sat);

endmodule

// ===== src/pcsp_fifo.sv =====
`timescale 1ns / 1ps
module pcsp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pcsp_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output pcsp_pkg::item_t item_o
);

  pcsp_pkg::item_t                 mem_q [pcsp_pkg::QueueDepth];
  logic [pcsp_pkg::PtrBits-1:0]    wr_ptr_q;
  logic [pcsp_pkg::PtrBits-1:0]    rd_ptr_q;
  logic [pcsp_pkg::PtrBits:0]      count_q;
  logic [pcsp_pkg::PtrBits:0]      count_d;

  assign full_o  = (count_q == (pcsp_pkg::PtrBits + 1)'(pcsp_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !(pop_i && valid_o)) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i && valid_o) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== src/pcsp_back.sv =====
`timescale 1ns / 1ps
module pcsp_back #(
  parameter int unsigned NUMBER_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  pcsp_pkg::item_t     item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcsp_pkg::out_word_t out_word_o
);

  localparam int unsigned MacBits = NUMBER_BITS + 4;

  localparam logic [3:0] PhFlags   = 4'd0;
  localparam logic [3:0] PhWDigits = 4'd1;
  localparam logic [3:0] PhPreDot  = 4'd2;
  localparam logic [3:0] PhDot     = 4'd3;
  localparam logic [3:0] PhPDigits = 4'd4;
  localparam logic [3:0] PhLen     = 4'd5;
  localparam logic [3:0] PhHOne    = 4'd6;
  localparam logic [3:0] PhHTwo    = 4'd7;
  localparam logic [3:0] PhLOne    = 4'd8;
  localparam logic [3:0] PhLTwo    = 4'd9;

  localparam int unsigned FbMinus = 0;
  localparam int unsigned FbPlus  = 1;
  localparam int unsigned FbSpace = 2;
  localparam int unsigned FbHash  = 3;
  localparam int unsigned FbZero  = 4;

  logic [3:0]                     phase_q, phase_d;
  logic [4:0]                     flags_q, flags_d;
  logic [NUMBER_BITS-1:0]         width_q, width_d;
  logic [NUMBER_BITS-1:0]         prec_q, prec_d;
  logic                           prec_none_q, prec_none_d;
  logic [pcsp_pkg::LenBits-1:0]   len_q, len_d;
  logic                           out_valid_q;
  pcsp_pkg::out_word_t            out_word_q, out_word_d;

  logic [3:0]                     p;
  logic                           taken;
  logic                           emit;
  logic                           is_digit;
  logic [NUMBER_BITS-1:0]         mac_base;
  logic [MacBits-1:0]             mac_full;
  logic [NUMBER_BITS-1:0]         mac_sum;
  logic [NUMBER_BITS-1:0]         star_val;

  assign pop_o       = item_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign is_digit = (item_i.cls == pcsp_pkg::ClsDigit) || (item_i.cls == pcsp_pkg::ClsZero);
  assign star_val = item_i.star_mag[NUMBER_BITS-1:0];

  // One shared multiply-by-ten step serves both number phases.
  always_comb begin
    if (phase_q == PhWDigits) begin
      mac_base = width_q;
    end else if (phase_q == PhPDigits) begin
      mac_base = prec_q;
    end else begin
      mac_base = '0;
    end
    mac_full = MacBits'({mac_base, 3'b000}) + MacBits'({mac_base, 1'b0})
             + MacBits'(item_i.character[3:0]);
    if (|mac_full[MacBits-1:NUMBER_BITS]) begin
      mac_sum = {NUMBER_BITS{1'b1}};
    end else begin
      mac_sum = mac_full[NUMBER_BITS-1:0];
    end
  end

  always_comb begin
    phase_d     = phase_q;
    flags_d     = flags_q;
    width_d     = width_q;
    prec_d      = prec_q;
    prec_none_d = prec_none_q;
    len_d       = len_q;
    p           = phase_q;
    taken       = 1'b0;
    emit        = 1'b0;
    out_word_d  = out_word_q;

    if (p == PhFlags) begin
      taken = 1'b1;
      case (item_i.cls)
        pcsp_pkg::ClsMinus: flags_d[FbMinus] = 1'b1;
        pcsp_pkg::ClsPlus:  flags_d[FbPlus]  = 1'b1;
        pcsp_pkg::ClsSpace: flags_d[FbSpace] = 1'b1;
        pcsp_pkg::ClsHash:  flags_d[FbHash]  = 1'b1;
        pcsp_pkg::ClsZero:  flags_d[FbZero]  = 1'b1;
        pcsp_pkg::ClsStar: begin
          if (item_i.star_neg) begin
            flags_d[FbMinus] = 1'b1;
          end
          width_d = star_val;
          phase_d = PhPreDot;
        end
        pcsp_pkg::ClsDigit: begin
          width_d = mac_sum;
          phase_d = PhWDigits;
        end
        default: begin
          taken = 1'b0;
          p     = PhPreDot;
        end
      endcase
    end

    if (!taken && p == PhWDigits) begin
      if (is_digit) begin
        width_d = mac_sum;
        taken   = 1'b1;
      end else begin
        p = PhPreDot;
      end
    end

    if (!taken && p == PhPreDot) begin
      if (item_i.cls == pcsp_pkg::ClsDot) begin
        prec_d      = '0;
        prec_none_d = 1'b0;
        phase_d     = PhDot;
        taken       = 1'b1;
      end else begin
        prec_none_d = 1'b1;
        p           = PhLen;
      end
    end

    if (!taken && p == PhDot) begin
      if (item_i.cls == pcsp_pkg::ClsStar) begin
        prec_d      = star_val;
        prec_none_d = item_i.star_neg;
        phase_d     = PhLen;
        taken       = 1'b1;
      end else if (is_digit) begin
        prec_d      = mac_sum;
        prec_none_d = 1'b0;
        phase_d     = PhPDigits;
        taken       = 1'b1;
      end else begin
        p = PhLen;
      end
    end

    if (!taken && p == PhPDigits) begin
      if (is_digit) begin
        prec_d = mac_sum;
        taken  = 1'b1;
      end else begin
        p = PhLen;
      end
    end

    if (!taken && (p == PhLen || p == PhHOne || p == PhHTwo)) begin
      if (item_i.cls == pcsp_pkg::ClsH && p != PhHTwo) begin
        len_d   = (p == PhLen) ? pcsp_pkg::LenH : pcsp_pkg::LenHh;
        phase_d = (p == PhLen) ? PhHOne : PhHTwo;
        taken   = 1'b1;
      end else if (item_i.cls == pcsp_pkg::ClsL) begin
        len_d   = pcsp_pkg::LenL;
        phase_d = PhLOne;
        taken   = 1'b1;
      end
    end else if (!taken && p == PhLOne) begin
      if (item_i.cls == pcsp_pkg::ClsL) begin
        len_d   = pcsp_pkg::LenLl;
        phase_d = PhLTwo;
        taken   = 1'b1;
      end
    end

    if (!taken) begin
      emit                       = 1'b1;
      out_word_d.left_justify    = flags_q[FbMinus];
      out_word_d.force_sign      = flags_q[FbPlus];
      out_word_d.space_sign      = flags_q[FbSpace] && !flags_q[FbPlus];
      out_word_d.alternate_form  = flags_q[FbHash];
      out_word_d.zero_pad        = flags_q[FbZero] && !flags_q[FbMinus];
      out_word_d.field_width     = pcsp_pkg::WidthBits'(width_q);
      out_word_d.precision_value = prec_none_d ? '1 : pcsp_pkg::PrecBits'(prec_d);
      out_word_d.length_code     = len_q;
      out_word_d.specifier       = item_i.character;
      phase_d                    = PhFlags;
      flags_d                    = '0;
      width_d                    = '0;
      prec_d                     = '0;
      prec_none_d                = 1'b0;
      len_d                      = pcsp_pkg::LenNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhFlags;
      flags_q     <= '0;
      width_q     <= '0;
      prec_q      <= '0;
      prec_none_q <= 1'b0;
      len_q       <= pcsp_pkg::LenNone;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q     <= phase_d;
        flags_q     <= flags_d;
        width_q     <= width_d;
        prec_q      <= prec_d;
        prec_none_q <= prec_none_d;
        len_q       <= len_d;
        out_valid_q <= emit;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

// ===== src/printf_conversion_spec_parser.sv =====
// Conversion specification parser for formatted output.
// Input channel: one word per character after the percent sign, with the next
// integer argument beside it, on in_valid_i / in_stall_o / in_word_i. A word is
// taken at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i / out_word_o carries one word per
// completed specification, holding flags, width, precision, length and the
// specifier character. Characters that only extend a specification give none.
// Throughput is one input word per cycle while in_stall_o is low. A result
// reaches out_valid_o by way of a two-entry queue, from which the phase
// sequencer loads the output register. The per-character step is one
// multiply by ten with saturation.
// While out_stall_i holds back a valid output word, that word holds, the
// sequencer stops taking characters, and the queue fills; in_stall_o rises
// when it is full.
// Reset clears the queue, the output valid flag and the parse state, leaving
// the block in the flag phase with no flags, zero width and no length.
`timescale 1ns / 1ps
module printf_conversion_spec_parser #(
  parameter int unsigned NUMBER_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pcsp_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcsp_pkg::out_word_t out_word_o
);

  pcsp_pkg::item_t front_item;
  pcsp_pkg::item_t queue_item;
  logic            queue_full;
  logic            queue_valid;
  logic            queue_pop;
  logic            queue_push;

  assign in_stall_o = queue_full;
  assign queue_push = in_valid_i && !queue_full;

  pcsp_front #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_front (
    .word_i(in_word_i),
    .item_o(front_item)
  );

  pcsp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (queue_push),
    .item_i (front_item),
    .full_o (queue_full),
    .pop_i  (queue_pop),
    .valid_o(queue_valid),
    .item_o (queue_item)
  );

  pcsp_back #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(queue_valid),
    .item_i      (queue_item),
    .pop_o       (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== src/pcsp_checker.sv =====
`timescale 1ns / 1ps
`include "printf_conversion_spec_parser_assert.svh"
module pcsp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pcsp_pkg::out_word_t out_word_o
);

  `PCSP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "stalled output word changed")
  `PCSP_ASSERT_IMPLIES(a_len_code, out_valid_o, out_word_o.length_code <= pcsp_pkg::LenL, "length code out of range")
  `PCSP_ASSERT_IMPLIES(a_flag_rules, out_valid_o, !(out_word_o.zero_pad && out_word_o.left_justify) && !(out_word_o.space_sign && out_word_o.force_sign), "flag cancel rule broken")
  `PCSP_ASSERT_IMPLIES(a_prec_neg, out_valid_o && out_word_o.precision_value[pcsp_pkg::PrecBits-1], &out_word_o.precision_value, "negative precision other than minus one")

endmodule

bind printf_conversion_spec_parser pcsp_checker u_checker (.*);
